// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros for the rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/stbs_pkg.sv =====
// ---------------------------------------------------------------------------
// stbs_pkg
// types and constants for the sort then binary search core
// ---------------------------------------------------------------------------
package stbs_pkg;

   localparam int MAX_ELEMENTS = 64;
   localparam int IDX_W        = $clog2(MAX_ELEMENTS);
   localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
   localparam int DATA_W       = 32;

   localparam logic ACTION_LOAD   = 1'b0;
   localparam logic ACTION_SEARCH = 1'b1;

   typedef struct packed {
      logic                     action;
      logic signed [DATA_W-1:0] value;
      logic                     last;
   } req_payload_type;

   typedef struct packed {
      logic                     found;
      logic        [5:0]        position;
      logic signed [DATA_W-1:0] key;
   } rsp_payload_type;

endpackage

// ===== rtl/sort_then_binary_search_core.sv =====
// ---------------------------------------------------------------------------
// sort_then_binary_search_core
// loads signed words into an array, sorts it ascending, answers key searches
// ---------------------------------------------------------------------------
// Load transfers (action 0) write one element per transfer into a 64 entry
// array held in a memory with one write port and one registered read port
// (one write, one registered read per cycle); a load gives no result. A load
// marked last closes the array and, when it holds two or more elements,
// starts a selection sort, during which the block stalls its input: for each
// position i from 0 to count-2 the sort reads element i, takes it, compares
// the rest through the read port (one element per cycle, pipelined) and
// writes the swap in two writes. A load after a closed array starts a new
// array, loads past 64 elements are dropped, and a last mark on a dropped
// load still sorts. A search transfer (action 1) runs a binary search of at
// most seven probes, each a read, then a compare; after a miss the window is
// found empty or closes below entry zero, and the result is then handed to
// the output register once it is free. Each search gives one result transfer
// carrying found, the sorted position of the first match on the midpoint path
// (0 when not found) and the key echoed back. A search with no closed array
// skips the probes and reports not found.
// Input is taken only while the sequencer is idle; a finished result sits in
// the output register and the next item may be taken while it waits.
// ---------------------------------------------------------------------------
module sort_then_binary_search_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  stbs_pkg::req_payload_type  req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output stbs_pkg::rsp_payload_type  rsp_payload
);

`include "assert_macros.svh"

   // sequencer states
   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_SORT_RDI = 9'b000000010,
      ST_SORT_LDI = 9'b000000100,
      ST_SORT_CMP = 9'b000001000,
      ST_SWAP_A   = 9'b000010000,
      ST_SWAP_B   = 9'b000100000,
      ST_SRCH_RD  = 9'b001000000,
      ST_SRCH_CMP = 9'b010000000,
      ST_SRCH_OUT = 9'b100000000
   } state_type;

   // control registers
   state_type                          state_ff, state_in;
   logic [stbs_pkg::CNT_W-1:0]         count_ff, count_in;
   logic                               closed_ff, closed_in;
   logic                               rsp_valid_ff, rsp_valid_in;

   // sort and search working registers
   logic [stbs_pkg::IDX_W-1:0]         i_ff, i_in;
   logic [stbs_pkg::IDX_W-1:0]         j_ff, j_in;
   logic [stbs_pkg::IDX_W-1:0]         best_ff, best_in;
   logic signed [stbs_pkg::DATA_W-1:0] ival_ff, ival_in;
   logic signed [stbs_pkg::DATA_W-1:0] bestval_ff, bestval_in;
   logic [stbs_pkg::CNT_W-1:0]         lo_ff, lo_in;
   logic [stbs_pkg::CNT_W-1:0]         hi_ff, hi_in;
   logic [stbs_pkg::IDX_W-1:0]         mid_ff, mid_in;
   logic signed [stbs_pkg::DATA_W-1:0] key_ff, key_in;
   logic                               found_ff, found_in;
   logic [stbs_pkg::IDX_W-1:0]         pos_ff, pos_in;
   stbs_pkg::rsp_payload_type          rsp_ff, rsp_in;

   // element memory
   logic signed [stbs_pkg::DATA_W-1:0] elem_mem_ff [stbs_pkg::MAX_ELEMENTS];
   logic signed [stbs_pkg::DATA_W-1:0] rd_data_ff;
   logic                               wr_en;
   logic [stbs_pkg::IDX_W-1:0]         wr_addr;
   logic signed [stbs_pkg::DATA_W-1:0] wr_data;
   logic [stbs_pkg::IDX_W-1:0]         rd_addr;

   // helpers
   logic                               req_xfer;
   logic                               rsp_xfer;
   logic                               out_free;
   logic [stbs_pkg::CNT_W-1:0]         load_base;
   logic [stbs_pkg::CNT_W:0]           mid_sum;
   logic [stbs_pkg::IDX_W-1:0]         mid_calc;
   logic [stbs_pkg::IDX_W-1:0]         i_next;
   logic [stbs_pkg::IDX_W-1:0]         j_next;

   assign req_stall   = (state_ff != ST_IDLE);
   assign req_xfer    = req_valid && !req_stall;
   assign rsp_xfer    = rsp_valid_ff && !rsp_stall;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // a load after a closed array restarts at entry zero
   assign load_base = closed_ff ? '0 : count_ff;
   // midpoint of the current search window, lo <= hi here
   assign mid_sum   = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_calc  = mid_sum[stbs_pkg::IDX_W:1];
   assign i_next    = i_ff + 1'b1;
   assign j_next    = j_ff + 1'b1;

   // memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         elem_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= elem_mem_ff[rd_addr];
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      closed_in    = closed_ff;
      rsp_valid_in = rsp_valid_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      best_in      = best_ff;
      ival_in      = ival_ff;
      bestval_in   = bestval_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      key_in       = key_ff;
      found_in     = found_ff;
      pos_in       = pos_ff;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = load_base[stbs_pkg::IDX_W-1:0];
      wr_data      = req_payload.value;
      rd_addr      = i_ff;

      // result register drains on its own transfer
      if (rsp_xfer) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_payload.action == stbs_pkg::ACTION_LOAD) begin
                  closed_in = 1'b0;
                  count_in  = load_base;
                  // drop loads past the array size
                  if (load_base < stbs_pkg::CNT_W'(stbs_pkg::MAX_ELEMENTS)) begin
                     wr_en    = 1'b1;
                     count_in = load_base + 1'b1;
                  end
                  if (req_payload.last) begin
                     closed_in = 1'b1;
                     i_in      = '0;
                     if (count_in >= stbs_pkg::CNT_W'(2)) begin
                        state_in = ST_SORT_RDI;
                     end
                  end
               end else begin
                  key_in   = req_payload.value;
                  found_in = 1'b0;
                  pos_in   = '0;
                  lo_in    = '0;
                  hi_in    = count_ff - 1'b1;
                  if (closed_ff && (count_ff != '0)) begin
                     state_in = ST_SRCH_RD;
                  end else begin
                     state_in = ST_SRCH_OUT;
                  end
               end
            end
         end

         ST_SORT_RDI: begin
            rd_addr  = i_ff;
            state_in = ST_SORT_LDI;
         end

         ST_SORT_LDI: begin
            // element i arrives, start scanning from i+1
            ival_in    = rd_data_ff;
            bestval_in = rd_data_ff;
            best_in    = i_ff;
            j_in       = i_next;
            rd_addr    = i_next;
            state_in   = ST_SORT_CMP;
         end

         ST_SORT_CMP: begin
            // first minimum wins on ties
            if (rd_data_ff < bestval_ff) begin
               bestval_in = rd_data_ff;
               best_in    = j_ff;
            end
            if ({1'b0, j_ff} == count_ff - 1'b1) begin
               state_in = ST_SWAP_A;
            end else begin
               j_in    = j_next;
               rd_addr = j_next;
            end
         end

         ST_SWAP_A: begin
            wr_en    = 1'b1;
            wr_addr  = best_ff;
            wr_data  = ival_ff;
            state_in = ST_SWAP_B;
         end

         ST_SWAP_B: begin
            wr_en   = 1'b1;
            wr_addr = i_ff;
            wr_data = bestval_ff;
            if ({1'b0, i_ff} == count_ff - stbs_pkg::CNT_W'(2)) begin
               state_in = ST_IDLE;
            end else begin
               i_in     = i_next;
               state_in = ST_SORT_RDI;
            end
         end

         ST_SRCH_RD: begin
            if (lo_ff > hi_ff) begin
               state_in = ST_SRCH_OUT;
            end else begin
               mid_in   = mid_calc;
               rd_addr  = mid_calc;
               state_in = ST_SRCH_CMP;
            end
         end

         ST_SRCH_CMP: begin
            if (rd_data_ff == key_ff) begin
               found_in = 1'b1;
               pos_in   = mid_ff;
               state_in = ST_SRCH_OUT;
            end else if (rd_data_ff < key_ff) begin
               lo_in    = {1'b0, mid_ff} + 1'b1;
               state_in = ST_SRCH_RD;
            end else if (mid_ff == '0) begin
               // window closes below entry zero
               state_in = ST_SRCH_OUT;
            end else begin
               hi_in    = {1'b0, mid_ff} - 1'b1;
               state_in = ST_SRCH_RD;
            end
         end

         ST_SRCH_OUT: begin
            if (out_free) begin
               rsp_in.found    = found_ff;
               rsp_in.position = 6'(pos_ff);
               rsp_in.key      = key_ff;
               rsp_valid_in    = 1'b1;
               state_in        = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         closed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         closed_ff    <= closed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      i_ff       <= i_in;
      j_ff       <= j_in;
      best_ff    <= best_in;
      ival_ff    <= ival_in;
      bestval_ff <= bestval_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      mid_ff     <= mid_in;
      key_ff     <= key_in;
      found_ff   <= found_in;
      pos_ff     <= pos_in;
      rsp_ff     <= rsp_in;
   end

   // checks
   `ASSERT_IMPLY(a_scan_in_range, clock, reset, (state_ff == ST_SORT_CMP), ({1'b0, j_ff} < count_ff), "sort scan index past element count")
   `ASSERT_IMPLY(a_probe_in_range, clock, reset, (state_ff == ST_SRCH_CMP), (closed_ff && ({1'b0, mid_ff} < count_ff)), "search probe outside closed array")
   `ASSERT_IMPLY(a_hit_in_range, clock, reset, ((state_ff == ST_SRCH_OUT) && found_ff), ({1'b0, pos_ff} < count_ff), "found position past element count")
   `ASSERT_NEXT(a_rsp_from_search, clock, reset, (!rsp_valid_ff && (state_ff != ST_SRCH_OUT)), !rsp_valid_ff, "result raised outside search completion")

endmodule

// ===== tb/sv/stbs_search_checker.sv =====
// ---------------------------------------------------------------------------
// stbs_search_checker
// predicts and checks the search results of the sort then binary search core
// ---------------------------------------------------------------------------
module stbs_search_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  stbs_pkg::req_payload_type req_payload,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  stbs_pkg::rsp_payload_type rsp_payload,
   output int                        mismatch_count,
   output int                        results_outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   logic signed [stbs_pkg::DATA_W-1:0] array_entries [stbs_pkg::MAX_ELEMENTS];
   int                                 loaded_count;
   bit                                 array_sorted;
   stbs_pkg::rsp_payload_type          expected_results [$];
   int                                 fails;

   // selection sort, first smallest on ties
   function automatic void sort_array();
      int                                 best;
      logic signed [stbs_pkg::DATA_W-1:0] tmp;
      for (int i = 0; i + 1 < loaded_count; i++) begin
         best = i;
         for (int j = i + 1; j < loaded_count; j++) begin
            if (array_entries[j] < array_entries[best]) best = j;
         end
         tmp                 = array_entries[i];
         array_entries[i]    = array_entries[best];
         array_entries[best] = tmp;
      end
   endfunction

   // binary search along the midpoint path
   function automatic stbs_pkg::rsp_payload_type look_up_key(
      logic signed [stbs_pkg::DATA_W-1:0] key);
      stbs_pkg::rsp_payload_type r;
      int                        lo;
      int                        hi;
      int                        mid;
      r.found    = 1'b0;
      r.position = '0;
      r.key      = key;
      if (array_sorted && loaded_count > 0) begin
         lo = 0;
         hi = loaded_count - 1;
         while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (array_entries[mid] == key) begin
               r.found    = 1'b1;
               r.position = mid[5:0];
               break;
            end
            if (array_entries[mid] < key) lo = mid + 1;
            else hi = mid - 1;
         end
      end
      return r;
   endfunction

   function automatic void take_request(stbs_pkg::req_payload_type item);
      if (item.action == stbs_pkg::ACTION_LOAD) begin
         if (array_sorted) begin
            loaded_count = 0;
            array_sorted = 1'b0;
         end
         if (loaded_count < stbs_pkg::MAX_ELEMENTS) begin
            array_entries[loaded_count] = item.value;
            loaded_count++;
         end
         if (item.last) begin
            sort_array();
            array_sorted = 1'b1;
         end
      end else begin
         expected_results.push_back(look_up_key(item.value));
      end
   endfunction

   function automatic void check_result(stbs_pkg::rsp_payload_type actual);
      stbs_pkg::rsp_payload_type exp_r;
      if (expected_results.size() == 0) begin
         $error("result transfer with no search waiting: key %0d", actual.key);
         fails++;
         return;
      end
      exp_r = expected_results.pop_front();
      if (actual.found !== exp_r.found) begin
         $error("found mismatch: expected %0d, actual %0d", exp_r.found, actual.found);
         fails++;
      end
      if (actual.position !== exp_r.position) begin
         $error("position mismatch: expected %0d, actual %0d",
                exp_r.position, actual.position);
         fails++;
      end
      if (actual.key !== exp_r.key) begin
         $error("key mismatch: expected %0d, actual %0d", exp_r.key, actual.key);
         fails++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         loaded_count = 0;
         array_sorted = 1'b0;
         fails        = 0;
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) check_result(rsp_payload);
         if (req_valid && !req_stall) take_request(req_payload);
      end
      mismatch_count      <= fails;
      results_outstanding <= expected_results.size();
   end

endmodule

// ===== tb/sv/sort_then_binary_search_core_tb.sv =====
// ---------------------------------------------------------------------------
// sort_then_binary_search_core_tb
// load, sort and search stimulus with random idling on both channels
// ---------------------------------------------------------------------------
// a directed run covers searches with no array, searches on an open array,
// the value extremes, duplicates and a one-entry array; random arrays of
// mostly small size follow, some overfilled, some left open, each followed by
// searches whose keys are mostly taken from the array. the checker beside the
// core predicts every result and counts mismatches.
// ---------------------------------------------------------------------------
module sort_then_binary_search_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   stbs_pkg::req_payload_type req_payload;
   logic                      rsp_valid;
   logic                      rsp_stall;
   stbs_pkg::rsp_payload_type rsp_payload;

   int mismatch_count;
   int results_outstanding;

   // idle chances in percent, per cycle
   int send_idle_pct = 29;
   int recv_idle_pct = 60;
   // asks the receiver for one long hold-off
   bit hold_request  = 1'b0;

   // values of the array being built, only to pick useful search keys
   logic signed [stbs_pkg::DATA_W-1:0] array_values [$];
   bit                                 array_done = 1'b0;

   sort_then_binary_search_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   stbs_search_checker search_check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_payload         (req_payload),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_payload         (rsp_payload),
      .mismatch_count      (mismatch_count),
      .results_outstanding (results_outstanding)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // receiver: random stalls, or one long hold-off on request so the core
   // fills its output register and then stalls its input
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (300) @(negedge clock);
            hold_request = 1'b0;
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         end
      end
   end

   // one input transfer; called and returns at a falling edge, valid is
   // lowered only in idle cycles so it never toggles within one step
   task automatic send_item(input logic act,
                            input logic signed [stbs_pkg::DATA_W-1:0] value,
                            input logic last);
      stbs_pkg::req_payload_type item;
      item.action = act;
      item.value  = value;
      item.last   = last;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      // payload held until the transfer is taken
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic load_value(input logic signed [stbs_pkg::DATA_W-1:0] value,
                             input logic last);
      // a load after a closed array begins a new one
      if (array_done) begin
         array_values.delete();
         array_done = 1'b0;
      end
      if (array_values.size() < stbs_pkg::MAX_ELEMENTS) array_values.push_back(value);
      if (last) array_done = 1'b1;
      send_item(stbs_pkg::ACTION_LOAD, value, last);
   endtask

   task automatic search_key(input logic signed [stbs_pkg::DATA_W-1:0] key,
                             input logic last);
      send_item(stbs_pkg::ACTION_SEARCH, key, last);
   endtask

   // small values give duplicates, full-width values reach every bit
   function automatic logic signed [stbs_pkg::DATA_W-1:0] random_value();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) return $signed($urandom_range(0, 16)) - 8;
      if (pick < 85) return $urandom;
      case ($urandom_range(0, 3))
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2: return 32'sh0000_0000;
         default: return -32'sd1;
      endcase
   endfunction

   // mostly hits, some near misses, some random keys
   function automatic logic signed [stbs_pkg::DATA_W-1:0] pick_key();
      int unsigned                        pick;
      logic signed [stbs_pkg::DATA_W-1:0] v;
      pick = $urandom_range(0, 99);
      if (array_values.size() == 0 || pick >= 80) return random_value();
      v = array_values[$urandom_range(0, array_values.size() - 1)];
      if (pick < 60) return v;
      if (pick < 70) return v + 1;
      return v - 1;
   endfunction

   // mostly small arrays, a few large ones up to full and a few overfilled ones
   function automatic int array_size();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return $urandom_range(1, 8);
      if (pick < 90) return $urandom_range(9, 32);
      if (pick < 97) return $urandom_range(33, stbs_pkg::MAX_ELEMENTS);
      return $urandom_range(stbs_pkg::MAX_ELEMENTS + 1, stbs_pkg::MAX_ELEMENTS + 6);
   endfunction

   // arrays followed by searches; now and then a search on an open array
   // or an array left without its last mark
   task automatic run_random_items(input int item_budget);
      int sent;
      int size;
      int searches;
      bit close_it;
      sent = 0;
      while (sent < item_budget) begin
         size     = array_size();
         close_it = ($urandom_range(0, 99) >= 5);
         for (int k = 0; k < size; k++) begin
            if ($urandom_range(0, 99) < 3) begin
               search_key(pick_key(), 1'($urandom_range(0, 1)));
               sent++;
            end
            load_value(random_value(), close_it && (k == size - 1));
         end
         searches = $urandom_range(2, 12);
         repeat (searches) search_key(pick_key(), 1'($urandom_range(0, 1)));
         sent += size + searches;
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // phase one: sender idles a little, receiver a lot
      send_idle_pct = 29;
      recv_idle_pct = 60;

      // search with no array loaded
      search_key(32'sd0, 1'b0);
      // search while the array is still open
      load_value(32'sh7FFF_FFFF, 1'b0);
      search_key(32'sh7FFF_FFFF, 1'b0);
      // extremes and a duplicate, closed by the last mark
      load_value(32'sh8000_0000, 1'b0);
      load_value(-32'sd1, 1'b0);
      load_value(32'sd5, 1'b0);
      load_value(32'sd5, 1'b0);
      load_value(32'sd0, 1'b1);
      search_key(32'sh8000_0000, 1'b0);
      search_key(32'sh7FFF_FFFF, 1'b1);
      search_key(32'sd5, 1'b0);
      search_key(32'sd3, 1'b0);
      search_key(-32'sd1, 1'b1);
      search_key(32'sd0, 1'b0);
      // load after a closed array starts a new one-entry array
      load_value(32'sd42, 1'b1);
      search_key(32'sd42, 1'b0);
      search_key(32'sd41, 1'b0);
      // two equal entries
      load_value(-32'sd7, 1'b0);
      load_value(-32'sd7, 1'b1);
      search_key(-32'sd7, 1'b0);
      search_key(32'shAAAA_AAAA, 1'b0);

      run_random_items(300);

      // phase two: the other way round
      send_idle_pct = 60;
      recv_idle_pct = 29;
      run_random_items(310);

      // phase three: no idling, one long receiver hold-off under searches
      send_idle_pct = 0;
      recv_idle_pct = 0;
      load_value(32'sd10, 1'b0);
      load_value(-32'sd20, 1'b0);
      load_value(32'sd30, 1'b1);
      hold_request = 1'b1;
      repeat (12) search_key(pick_key(), 1'b0);
      run_random_items(300);

      req_valid <= 1'b0;
      while (results_outstanding != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      if (mismatch_count == 0 && results_outstanding == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/stbs_pkg.sv
rtl/sort_then_binary_search_core.sv
tb/sv/stbs_search_checker.sv
tb/sv/sort_then_binary_search_core_tb.sv
